@@ rtl/qtpd_pkg.sv @@
// Shared types, register indexes and a helper function of the quadrature tone power detector.
package qtpd_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned PHASE_W  = 16;
    localparam int unsigned ACC_W    = 16;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned POWER_W  = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SHIFT_W-1:0] FILTER_SHIFT_RESET = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC    = 1'b0,
        REG_FILTER_SHIFT = 1'b1
    } t_cfg_reg;

    // The two integrator values that one sample leaves behind.
    typedef struct packed {
        logic [ACC_W-1:0] inphase;
        logic [ACC_W-1:0] quadrature;
    } t_iq_acc;

    // Arithmetic right shift of a two's complement integrator value.
    function automatic logic [ACC_W-1:0] asr_acc(input logic [ACC_W-1:0] v,
                                                 input logic [SHIFT_W-1:0] s);
        asr_acc = ACC_W'($signed(v) >>> s);
    endfunction

endpackage

@@ rtl/quadrature_tone_power_detector.sv @@
// Top level of the quadrature tone power detector: configuration registers and flow control.
//
// The block takes one signed 8-bit sample per request and returns one 16-bit tone power per
// request, i*i + q*q of the low-pass filtered in-phase and quadrature mixer outputs. It sustains
// one request per clock cycle while the output is not stalled: the oscillator phase and both
// leaky integrators are updated in the cycle the sample is accepted, which is the only loop in
// the design. The power of that sample is squared from the stored integrators and lands in the
// result register once that register is free or being emptied, and stays offered there until the
// consumer collects it. The mixer stage and the result register each hold one request, so a
// new sample is still accepted while a finished result waits for the consumer; the input
// stalls only when both are full and the output is stalled. Configuration writes are always
// ready; the phase increment and the filter shift should be changed only while no request is
// in flight.
module quadrature_tone_power_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [qtpd_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [qtpd_pkg::POWER_W-1:0]         o_tone_power,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [qtpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qtpd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import qtpd_pkg::*;

    logic [PHASE_W-1:0] r_phase_inc, n_phase_inc;
    logic [SHIFT_W-1:0] r_filter_shift, n_filter_shift;
    logic               accept;
    logic               mix_valid;
    logic               mix_take;
    t_iq_acc            mix_acc;
    t_cfg_reg           cfg_reg;

    // Configuration writes are registered directly, so the port never pushes back.
    assign o_cfg_ready = 1'b1;
    assign cfg_reg     = t_cfg_reg'(i_cfg_index);

    always_comb begin
        n_phase_inc    = r_phase_inc;
        n_filter_shift = r_filter_shift;
        if (i_cfg_valid) begin
            unique case (cfg_reg)
                REG_PHASE_INC:    n_phase_inc    = i_cfg_data[PHASE_W-1:0];
                REG_FILTER_SHIFT: n_filter_shift = i_cfg_data[SHIFT_W-1:0];
                default:          n_phase_inc    = r_phase_inc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc    <= '0;
            r_filter_shift <= FILTER_SHIFT_RESET;
        end else begin
            r_phase_inc    <= n_phase_inc;
            r_filter_shift <= n_filter_shift;
        end
    end

    // The mixer stage may take a new sample when it is empty or hands its contents on this cycle.
    assign o_in_stall = mix_valid && !mix_take;
    assign accept     = i_in_valid && !o_in_stall;

    qtpd_mixer u_mixer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_advance         (mix_take),
        .i_sample_value    (i_sample_value),
        .i_phase_increment (r_phase_inc),
        .i_filter_shift    (r_filter_shift),
        .o_valid           (mix_valid),
        .o_acc             (mix_acc)
    );

    qtpd_power u_power (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (mix_valid),
        .i_acc          (mix_acc),
        .i_filter_shift (r_filter_shift),
        .i_out_stall    (i_out_stall),
        .o_take         (mix_take),
        .o_out_valid    (o_out_valid),
        .o_tone_power   (o_tone_power)
    );

`ifndef ASSERT_OFF
    // An empty mixer stage never holds back the input.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mix_valid |-> !o_in_stall)
        else $error("input stalled while the mixer stage is empty");

    // A sample taken in leaves the mixer stage holding a request.
    a_accept_fills_mixer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> mix_valid)
        else $error("accepted sample did not reach the mixer stage");

    // A request handed on from the mixer stage is offered at the output next cycle.
    a_take_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_take |=> o_out_valid)
        else $error("request handed to the result register was lost");

    // With both stages full and the output stalled, the input must stall.
    a_full_pipe_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mix_valid && o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input not stalled while both stages are full");
`endif

endmodule

@@ rtl/qtpd_mixer.sv @@
// Local oscillator, square-wave mixing and the two leaky integrators.
module qtpd_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_advance,
    input  logic signed [qtpd_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [qtpd_pkg::PHASE_W-1:0]        i_phase_increment,
    input  logic [qtpd_pkg::SHIFT_W-1:0]        i_filter_shift,
    output logic                                o_valid,
    output qtpd_pkg::t_iq_acc                   o_acc
);
    import qtpd_pkg::*;

    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [ACC_W-1:0]    r_acc_i, n_acc_i;
    logic [ACC_W-1:0]    r_acc_q, n_acc_q;
    logic                r_valid, n_valid;
    logic                inv_i, inv_q;
    logic [SAMPLE_W-1:0] prod_i, prod_q;

    always_comb begin
        n_phase = r_phase + i_phase_increment;
        // The quadrature wave is negative when bit 15 of phase plus a quarter turn is set.
        inv_i   = n_phase[PHASE_W-1];
        inv_q   = n_phase[PHASE_W-1] ^ n_phase[PHASE_W-2];
        prod_i  = i_sample_value ^ {SAMPLE_W{inv_i}};
        prod_q  = i_sample_value ^ {SAMPLE_W{inv_q}};
        n_acc_i = r_acc_i + {{(ACC_W-SAMPLE_W){prod_i[SAMPLE_W-1]}}, prod_i}
                  - asr_acc(r_acc_i, i_filter_shift);
        n_acc_q = r_acc_q + {{(ACC_W-SAMPLE_W){prod_q[SAMPLE_W-1]}}, prod_q}
                  - asr_acc(r_acc_q, i_filter_shift);
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_acc_i <= '0;
            r_acc_q <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_accept) begin
                r_phase <= n_phase;
                r_acc_i <= n_acc_i;
                r_acc_q <= n_acc_q;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_acc.inphase    = r_acc_i;
    assign o_acc.quadrature = r_acc_q;

endmodule

@@ rtl/qtpd_power.sv @@
// Scaling of the integrators, squaring and the result register.
module qtpd_power (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  qtpd_pkg::t_iq_acc             i_acc,
    input  logic [qtpd_pkg::SHIFT_W-1:0]  i_filter_shift,
    input  logic                          i_out_stall,
    output logic                          o_take,
    output logic                          o_out_valid,
    output logic [qtpd_pkg::POWER_W-1:0]  o_tone_power
);
    import qtpd_pkg::*;

    logic                       r_out_valid, n_out_valid;
    logic [POWER_W-1:0]         r_power, n_power;
    logic signed [SAMPLE_W-1:0] comp_i, comp_q;
    logic signed [POWER_W-1:0]  sq_i, sq_q;
    logic                       take;

    always_comb begin
        // Each filtered component wraps to a signed byte before squaring.
        comp_i  = SAMPLE_W'(asr_acc(i_acc.inphase, i_filter_shift));
        comp_q  = SAMPLE_W'(asr_acc(i_acc.quadrature, i_filter_shift));
        sq_i    = POWER_W'(comp_i) * POWER_W'(comp_i);
        sq_q    = POWER_W'(comp_q) * POWER_W'(comp_q);
        n_power = POWER_W'(sq_i) + POWER_W'(sq_q);
        take    = i_valid && (!r_out_valid || !i_out_stall);
        if (take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_power <= n_power;
        end
    end

    assign o_take       = take;
    assign o_out_valid  = r_out_valid;
    assign o_tone_power = r_power;

endmodule

@@ bench/quadrature_tone_power_detector_tb.sv @@
// Self-checking testbench for the quadrature tone power detector, with a cycle-free predictor.
module quadrature_tone_power_detector_tb;

    import qtpd_pkg::*;

    // The run is bounded by a cycle counter. The slowest correct run is roughly 1700 requests,
    // each with random idle time on the input and random stalls on the output, plus the drain
    // before every register write, and it stays well inside this limit.
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 140;
    localparam int MAX_WAIT       = 14;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int SIDE_IN        = 0;
    localparam int SIDE_OUT       = 1;

    localparam logic [PHASE_W-1:0]  QUARTER_TURN = 16'h4000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = 8'h80;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 8'h7F;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG1  = 8'hFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO  = 8'h00;

    typedef enum logic {
        STEP_WRITE  = 1'b0,
        STEP_SAMPLE = 1'b1
    } t_step_kind;

    // One row of the directed plan: either a register write or a sample request. A sample row
    // may carry a power value typed in by hand; otherwise the predictor supplies it.
    typedef struct packed {
        t_step_kind             kind;
        t_cfg_reg               reg_sel;
        logic [CFG_DATA_W-1:0]  value;
        logic                   has_power;
        logic [POWER_W-1:0]     power;
    } t_step_row;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample_value = '0;
    logic                  i_out_stall    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    logic [POWER_W-1:0]    o_tone_power;

    // Predictor state: oscillator phase, both integrators and the current register values.
    logic [PHASE_W-1:0]    lo_phase;
    logic [ACC_W-1:0]      integ_i;
    logic [ACC_W-1:0]      integ_q;
    logic [PHASE_W-1:0]    cur_inc;
    logic [SHIFT_W-1:0]    cur_shift;

    // Tone powers still owed by the block, oldest first.
    logic [POWER_W-1:0]    expected_power[$];

    int errors        = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int writes_done   = 0;
    int cycles        = 0;
    int calm_left[2]  = '{0, 0};

    quadrature_tone_power_detector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tone_power   (o_tone_power),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Idle cycles before the next request on one side. Now and then a side enters a calm
    // stretch in which it never idles, so that back-to-back traffic is exercised as well.
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left[side] = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // The leak term of an integrator: an arithmetic shift right of a two's complement value.
    function automatic logic [ACC_W-1:0] leak_of(input logic [ACC_W-1:0] acc,
                                                 input logic [SHIFT_W-1:0] sh);
        logic signed [ACC_W-1:0] acc_s;
        acc_s = acc;
        return acc_s >>> sh;
    endfunction

    // Advances the oscillator, mixes the sample with both square waves, updates the two leaky
    // integrators and returns the power of the filtered components, each wrapped to 8 bits.
    function automatic logic [POWER_W-1:0] predict_tone_power(input logic [SAMPLE_W-1:0] s);
        logic [PHASE_W-1:0]         quad_phase;
        logic [SAMPLE_W-1:0]        mix_i;
        logic [SAMPLE_W-1:0]        mix_q;
        logic [ACC_W-1:0]           filt_i;
        logic [ACC_W-1:0]           filt_q;
        logic signed [SAMPLE_W-1:0] comp_i;
        logic signed [SAMPLE_W-1:0] comp_q;
        int                         ii;
        int                         qq;
        lo_phase   = lo_phase + cur_inc;
        quad_phase = lo_phase + QUARTER_TURN;
        // A negative half of a square wave is a bitwise inversion, i.e. -1 - x.
        mix_i   = lo_phase[PHASE_W-1]   ? ~s : s;
        mix_q   = quad_phase[PHASE_W-1] ? ~s : s;
        integ_i = integ_i + {{(ACC_W-SAMPLE_W){mix_i[SAMPLE_W-1]}}, mix_i}
                  - leak_of(integ_i, cur_shift);
        integ_q = integ_q + {{(ACC_W-SAMPLE_W){mix_q[SAMPLE_W-1]}}, mix_q}
                  - leak_of(integ_q, cur_shift);
        filt_i  = leak_of(integ_i, cur_shift);
        filt_q  = leak_of(integ_q, cur_shift);
        comp_i  = filt_i[SAMPLE_W-1:0];
        comp_q  = filt_q[SAMPLE_W-1:0];
        ii = comp_i;
        qq = comp_q;
        return POWER_W'(ii * ii + qq * qq);
    endfunction

    function automatic t_step_row sample_row(input logic [SAMPLE_W-1:0] s,
                                             input logic has_power,
                                             input logic [POWER_W-1:0] power);
        t_step_row row;
        row.kind      = STEP_SAMPLE;
        row.reg_sel   = REG_PHASE_INC;
        row.value     = CFG_DATA_W'(s);
        row.has_power = has_power;
        row.power     = power;
        return row;
    endfunction

    function automatic t_step_row write_row(input t_cfg_reg reg_sel,
                                            input logic [CFG_DATA_W-1:0] value);
        t_step_row row;
        row.kind      = STEP_WRITE;
        row.reg_sel   = reg_sel;
        row.value     = value;
        row.has_power = 1'b0;
        row.power     = '0;
        return row;
    endfunction

    // Chooses the next random sample. Two in five requests follow a square tone locked to the local
    // oscillator so that the integrators charge up to large values; the rest are full-range
    // noise, field extremes and small values around zero.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int amp);
        logic [PHASE_W-1:0] next_phase;
        next_phase = lo_phase + cur_inc;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return next_phase[PHASE_W-1] ? SAMPLE_W'(-amp) : SAMPLE_W'(amp);
            4, 5:       return SAMPLE_W'($urandom_range(0, 255));
            6, 7: begin
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return SAMPLE_NEG1;
                    default: return SAMPLE_ZERO;
                endcase
            end
            default:    return SAMPLE_W'(int'($urandom_range(0, 7)) - 4);
        endcase
    endfunction

    // Offers one sample request. The input side first idles for a random number of cycles;
    // valid then stays high with a steady payload until a rising edge finds stall low. The
    // expectation is recorded at that very edge, before the result can appear.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] s,
                                input logic has_power,
                                input logic [POWER_W-1:0] typed_power);
        int                 gap;
        logic [POWER_W-1:0] power;
        gap = draw_wait(SIDE_IN);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_sample_value <= s;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        power = predict_tone_power(s);
        expected_power.push_back(has_power ? typed_power : power);
        samples_sent++;
    endtask

    // Writes one register once the block is idle: every owed result has arrived and the drain
    // wait has passed for the two-stage pipeline to empty.
    task automatic write_register(input t_cfg_reg reg_sel, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (expected_power.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_sel;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (reg_sel == REG_PHASE_INC) begin
            cur_inc = value;
        end else begin
            cur_shift = value[SHIFT_W-1:0];
        end
        writes_done++;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Result side: stall for a random number of cycles, then take the next result and compare
    // it with the oldest expectation.
    initial begin : result_checker
        int                 gap;
        logic [POWER_W-1:0] want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait(SIDE_OUT);
            if (gap > 0) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            results_seen++;
            if (expected_power.size() == 0) begin
                errors++;
                $display("%0t: tone power %0d arrived with no request outstanding",
                         $time, o_tone_power);
            end else begin
                want = expected_power.pop_front();
                if (o_tone_power !== want) begin
                    errors++;
                    $display("%0t: tone_power mismatch, expected %0d, actual %0d",
                             $time, want, o_tone_power);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: run timed out after %0d cycles", $time, cycles);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        t_step_row          plan[$];
        t_step_row          row;
        int                 amp;
        logic [PHASE_W-1:0] inc;
        logic [SHIFT_W-1:0] sh;

        lo_phase  = '0;
        integ_i   = '0;
        integ_q   = '0;
        cur_inc   = '0;
        cur_shift = FILTER_SHIFT_RESET;

        // Straight after reset the step is zero and the shift is four: a zero sample gives
        // zero power. The first extremes then charge both integrators in step.
        plan.push_back(sample_row(SAMPLE_ZERO, 1'b1, 16'd0));
        plan.push_back(sample_row(SAMPLE_MAX,  1'b0, 16'd0));
        plan.push_back(sample_row(SAMPLE_MIN,  1'b0, 16'd0));
        // With a shift of zero each integrator simply takes its product, so the power is
        // twice the square of the sample while the oscillator rests at phase zero.
        plan.push_back(write_row(REG_FILTER_SHIFT, 16'd0));
        plan.push_back(sample_row(SAMPLE_MIN,  1'b1, 16'd32768));
        plan.push_back(sample_row(SAMPLE_MAX,  1'b1, 16'd32258));
        plan.push_back(sample_row(SAMPLE_ZERO, 1'b1, 16'd0));
        plan.push_back(sample_row(SAMPLE_NEG1, 1'b1, 16'd2));
        // Half a turn per sample: at phase 0x8000 both waves are negative, so a zero sample
        // becomes -1 in both arms; the next step returns to phase zero.
        plan.push_back(write_row(REG_PHASE_INC, 16'h8000));
        plan.push_back(sample_row(SAMPLE_ZERO, 1'b1, 16'd2));
        plan.push_back(sample_row(SAMPLE_ZERO, 1'b1, 16'd0));
        // A quarter turn per sample separates the arms: at phase 0x4000 only the quadrature
        // wave is negative, so 5 gives 5 and -6.
        plan.push_back(write_row(REG_PHASE_INC, QUARTER_TURN));
        plan.push_back(sample_row(8'd5, 1'b1, 16'd61));
        plan.push_back(sample_row(8'd5, 1'b0, 16'd0));
        plan.push_back(sample_row(8'd5, 1'b0, 16'd0));
        // Longest time constant with the largest step, then a shift of one with the smallest step.
        plan.push_back(write_row(REG_FILTER_SHIFT, 16'd7));
        plan.push_back(write_row(REG_PHASE_INC, 16'hFFFF));
        repeat (3) plan.push_back(sample_row(SAMPLE_MAX, 1'b0, 16'd0));
        repeat (3) plan.push_back(sample_row(SAMPLE_MIN, 1'b0, 16'd0));
        plan.push_back(write_row(REG_FILTER_SHIFT, 16'd1));
        plan.push_back(write_row(REG_PHASE_INC, 16'd1));
        plan.push_back(sample_row(SAMPLE_MIN, 1'b0, 16'd0));
        plan.push_back(sample_row(SAMPLE_MAX, 1'b0, 16'd0));
        plan.push_back(sample_row(8'h55, 1'b0, 16'd0));
        plan.push_back(sample_row(8'hAA, 1'b0, 16'd0));

        // Synchronous reset, held from the start of the run and released once, on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            row = plan[n];
            if (row.kind == STEP_WRITE) begin
                write_register(row.reg_sel, row.value);
            end else begin
                offer_sample(row.value[SAMPLE_W-1:0], row.has_power, row.power);
            end
        end

        // Random phases. The first few pin the register extremes, including the shift of
        // zero; later ones favour slow tones with the odd arbitrary step.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin inc = 16'd0;     sh = 3'd1; end
                1:       begin inc = 16'hFFFF;  sh = 3'd7; end
                2:       begin inc = 16'd1;     sh = 3'd7; end
                3:       begin inc = 16'h8000;  sh = 3'd1; end
                4:       begin inc = QUARTER_TURN; sh = 3'd0; end
                default: begin
                    inc = ($urandom_range(0, 3) == 0) ? PHASE_W'($urandom_range(0, 65535))
                                                      : PHASE_W'($urandom_range(1, 4096));
                    sh  = SHIFT_W'($urandom_range(1, 7));
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_register(REG_PHASE_INC, inc);
                write_register(REG_FILTER_SHIFT, CFG_DATA_W'(sh));
            end else begin
                write_register(REG_FILTER_SHIFT, CFG_DATA_W'(sh));
                write_register(REG_PHASE_INC, inc);
            end
            amp = $urandom_range(1, 127);
            repeat (PHASE_REQUESTS) offer_sample(pick_sample(amp), 1'b0, '0);
        end

        // Drain: every owed result must arrive, then a quiet drain wait catches any extra one.
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (expected_power.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d sample requests and %0d register writes; %0d results checked.",
                 samples_sent, writes_done, results_seen);
        $display("Phase steps from 0 to 0xFFFF and filter shifts from 0 to 7, %0d failures.",
                 errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/qtpd_pkg.sv
rtl/qtpd_mixer.sv
rtl/qtpd_power.sv
rtl/quadrature_tone_power_detector.sv
bench/quadrature_tone_power_detector_tb.sv
